// File: rtl/brbf_pkg.sv
// ----------------------------------------------------------------------------
// brbf_pkg - shared definitions for the byte ring buffer FIFO
// Store geometry, operation and status codes, and the request record that
// travels from the front end through the request queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package brbf_pkg;

  // Store geometry; the depth is a power of two so pointers wrap by themselves
  localparam int DEPTH    = 4096;
  localparam int AW       = $clog2(DEPTH);
  localparam int FW       = AW + 1;
  localparam int MAX_READ = 64;

  // Field widths of the streams
  localparam int OPW  = 2;
  localparam int BW   = 8;
  localparam int RCW  = 7;
  localparam int DCW  = 16;
  localparam int STW  = 2;

  // Packed stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = OPW;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = STW + 1;

  // Request queue between front and back end
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Operation codes on the input stream
  localparam logic [OPW-1:0] OP_WRITE   = 2'd0;
  localparam logic [OPW-1:0] OP_READ    = 2'd1;
  localparam logic [OPW-1:0] OP_DISCARD = 2'd2;
  localparam logic [OPW-1:0] OP_NONE    = 2'd3;

  // Result status codes
  typedef enum logic [STW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Classified request kind
  typedef enum logic [1:0] {
    K_WRITE,
    K_READ,
    K_DISCARD,
    K_NOP
  } cmd_kind_t;

  // Back end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

  // One classified request
  typedef struct packed {
    cmd_kind_t            kind;
    logic [BW-1:0]        wdata;
    logic [RCW-1:0]       count;   // read count, already limited to MAX_READ
    logic [DCW-1:0]       dcount;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/byte_ring_buffer_fifo_core.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_fifo_core - byte FIFO in a circular store
// Write, read and discard requests against a 4096-byte ring buffer with
// read/write pointers and a fill count; each result reports the fill level.
//
//   channel   dir   payload                                      handshake
//   in_*      in    tdata: write_data, read_count, discard_count tvalid/tready
//                   tuser: op
//   out_*     out   tdata: read_data, fill_level                 tvalid/tready
//                   tuser: status, data_valid; tlast: last
//
// A write, discard, short read, zero read or unused request gives a single
// result from the idle state. A read of N bytes first fetches the head, then
// emits the bytes from the store's registered read port as the output drains.
// A two-entry request queue lets intake continue while the back end works.
// Reset clears pointers, fill count and queue; store contents stay undefined.
// Output stalls hold the result register and pause the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_fifo_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [7:0] write_data, [14:8] read_count, [30:15] discard_count, [31] zero
  input  wire logic [brbf_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] op
  input  wire logic [brbf_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [7:0] read_data, [20:8] fill_level, [23:21] zero
  output logic [brbf_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // [1:0] status, [2] data_valid
  output logic [brbf_pkg::OUT_TUSER_W-1:0]       out_tuser,
  output logic                                   out_tlast
);

  logic           cmd_valid;
  logic           cmd_ready;
  brbf_pkg::cmd_t cmd;

  // Intake and classification
  brbf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Execution against the ring buffer
  brbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// File: rtl/brbf_ram.sv
// ----------------------------------------------------------------------------
// brbf_ram - generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module brbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/brbf_front.sv
// ----------------------------------------------------------------------------
// brbf_front - request intake and classification
// Decodes the operation, limits the read count to MAX_READ and holds
// classified requests in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module brbf_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [brbf_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [brbf_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                                   cmd_valid,
  input  wire logic                              cmd_ready,
  output brbf_pkg::cmd_t                         cmd
);

  brbf_pkg::cmd_t               cmd_in;
  logic [brbf_pkg::RCW-1:0]     rcount;
  brbf_pkg::cmd_t               q_r [brbf_pkg::QDEPTH];
  logic [brbf_pkg::QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [brbf_pkg::QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [brbf_pkg::QCW-1:0]     cnt_r, cnt_nxt;
  logic                         push, pop;

  // Classify the incoming request
  always_comb begin
    rcount = in_tdata[14:8];
    if (rcount > brbf_pkg::RCW'(brbf_pkg::MAX_READ)) begin
      rcount = brbf_pkg::RCW'(brbf_pkg::MAX_READ);
    end
    cmd_in.wdata  = in_tdata[7:0];
    cmd_in.count  = rcount;
    cmd_in.dcount = in_tdata[30:15];
    unique case (in_tuser)
      brbf_pkg::OP_WRITE:   cmd_in.kind = brbf_pkg::K_WRITE;
      brbf_pkg::OP_READ:    cmd_in.kind = brbf_pkg::K_READ;
      brbf_pkg::OP_DISCARD: cmd_in.kind = brbf_pkg::K_DISCARD;
      default:              cmd_in.kind = brbf_pkg::K_NOP;
    endcase
  end

  // Queue handshakes
  assign in_tready = (cnt_r != brbf_pkg::QCW'(brbf_pkg::QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store request payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/brbf_back.sv
// ----------------------------------------------------------------------------
// brbf_back - ring buffer execution
// Owns the pointers, the fill count and the byte store; carries out one
// request at a time and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module brbf_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_ready,
  input  wire brbf_pkg::cmd_t                    cmd,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [brbf_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic [brbf_pkg::OUT_TUSER_W-1:0]       out_tuser,
  output logic                                   out_tlast
);

  localparam logic [brbf_pkg::FW-1:0] FULL_LEVEL = brbf_pkg::FW'(brbf_pkg::DEPTH);

  brbf_pkg::back_state_t        state_r, state_nxt;
  logic [brbf_pkg::AW-1:0]      rptr_r, rptr_nxt;
  logic [brbf_pkg::AW-1:0]      wptr_r, wptr_nxt;
  logic [brbf_pkg::FW-1:0]      fill_r, fill_nxt;
  logic [brbf_pkg::RCW-1:0]     rem_r, rem_nxt;

  logic                         ov_r, ov_nxt;
  brbf_pkg::status_t            ost_r, ost_nxt;
  logic [brbf_pkg::BW-1:0]      odat_r, odat_nxt;
  logic                         odv_r, odv_nxt;
  logic [brbf_pkg::FW-1:0]      ofill_r, ofill_nxt;
  logic                         olast_r, olast_nxt;

  logic                         out_free;
  logic                         ram_we, ram_re;
  logic [brbf_pkg::AW-1:0]      ram_raddr;
  logic [brbf_pkg::BW-1:0]      ram_rdata;
  logic [brbf_pkg::FW-1:0]      drop_n;

  assign out_free = !ov_r || out_tready;

  // Byte store
  brbf_ram #(
    .WIDTH (brbf_pkg::BW),
    .DEPTH (brbf_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wptr_r),
    .wr_data (cmd.wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Bytes a discard drops: limited to the fill level
  assign drop_n = ({{(brbf_pkg::DCW-brbf_pkg::FW){1'b0}}, fill_r} < cmd.dcount)
                  ? fill_r : cmd.dcount[brbf_pkg::FW-1:0];

  // Sequence requests and build results
  always_comb begin
    state_nxt = state_r;
    rptr_nxt  = rptr_r;
    wptr_nxt  = wptr_r;
    fill_nxt  = fill_r;
    rem_nxt   = rem_r;
    ov_nxt    = ov_r && !out_tready;
    ost_nxt   = ost_r;
    odat_nxt  = odat_r;
    odv_nxt   = odv_r;
    ofill_nxt = ofill_r;
    olast_nxt = olast_r;
    cmd_ready = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rptr_r;

    unique case (state_r)
      brbf_pkg::BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          // default single result: status ok, no data, level unchanged
          ov_nxt    = 1'b1;
          ost_nxt   = brbf_pkg::ST_OK;
          odat_nxt  = '0;
          odv_nxt   = 1'b0;
          ofill_nxt = fill_r;
          olast_nxt = 1'b1;
          unique case (cmd.kind)
            brbf_pkg::K_WRITE: begin
              if (fill_r == FULL_LEVEL) begin
                ost_nxt = brbf_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                wptr_nxt  = wptr_r + 1'b1;
                fill_nxt  = fill_r + 1'b1;
                ofill_nxt = fill_r + 1'b1;
              end
            end
            brbf_pkg::K_READ: begin
              if ({{(brbf_pkg::FW-brbf_pkg::RCW){1'b0}}, cmd.count} > fill_r) begin
                ost_nxt = brbf_pkg::ST_SHORT;
              end else if (cmd.count != '0) begin
                // fetch the head byte; results follow from the read state
                ov_nxt    = 1'b0;
                ram_re    = 1'b1;
                rem_nxt   = cmd.count;
                state_nxt = brbf_pkg::BK_READ;
              end
            end
            brbf_pkg::K_DISCARD: begin
              if (fill_r == '0) begin
                ost_nxt = brbf_pkg::ST_EMPTY;
              end else begin
                rptr_nxt  = rptr_r + drop_n[brbf_pkg::AW-1:0];
                fill_nxt  = fill_r - drop_n;
                ofill_nxt = fill_r - drop_n;
              end
            end
            default: begin
            end
          endcase
        end
      end

      brbf_pkg::BK_READ: begin
        // emit the fetched byte and fetch the next one in the same cycle
        if (out_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = brbf_pkg::ST_OK;
          odat_nxt  = ram_rdata;
          odv_nxt   = 1'b1;
          ofill_nxt = fill_r - 1'b1;
          olast_nxt = (rem_r == brbf_pkg::RCW'(1));
          rptr_nxt  = rptr_r + 1'b1;
          fill_nxt  = fill_r - 1'b1;
          rem_nxt   = rem_r - 1'b1;
          if (rem_r == brbf_pkg::RCW'(1)) begin
            state_nxt = brbf_pkg::BK_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rptr_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = brbf_pkg::BK_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brbf_pkg::BK_IDLE;
      rptr_r  <= '0;
      wptr_r  <= '0;
      fill_r  <= '0;
      rem_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rptr_r  <= rptr_nxt;
      wptr_r  <= wptr_nxt;
      fill_r  <= fill_nxt;
      rem_r   <= rem_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    ost_r   <= ost_nxt;
    odat_r  <= odat_nxt;
    odv_r   <= odv_nxt;
    ofill_r <= ofill_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {3'b000, ofill_r, odat_r};
  assign out_tuser  = {odv_r, ost_r};
  assign out_tlast  = olast_r;

endmodule

`default_nettype wire

// File: rtl/brbf_checker.sv
// ----------------------------------------------------------------------------
// brbf_checker - port-level checks for the byte ring buffer FIFO
// Watches the result stream for stall stability and consistent status,
// data and fill level fields.
// ----------------------------------------------------------------------------
`default_nettype none

module brbf_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [brbf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic [brbf_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input wire logic                              out_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // A byte result always carries status ok
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == brbf_pkg::ST_OK)
    else $error("data result with error status");

  // A result without a byte is the only result of its request and has no data
  a_nodata_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tlast && out_tdata[7:0] == '0)
    else $error("non-data result not final or carries data");

  // Full status only at full level
  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == brbf_pkg::ST_FULL |->
    out_tdata[20:8] == brbf_pkg::FW'(brbf_pkg::DEPTH))
    else $error("full status below full level");

  // Discard-while-empty reports an empty buffer
  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == brbf_pkg::ST_EMPTY |-> out_tdata[20:8] == '0)
    else $error("empty status with bytes held");

endmodule

bind byte_ring_buffer_fifo_core brbf_checker u_brbf_checker (.*);

`default_nettype wire

// File: test/byte_ring_buffer_fifo_core_check.sv
// ----------------------------------------------------------------------------
// Byte ring buffer FIFO result checker
// Watches both streams of the FIFO core, keeps its own copy of the ring
// store, pointers and fill count, works out the results of every accepted
// request and compares each accepted result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_ring_buffer_fifo_core_check
  import brbf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  // [7:0] write_data, [14:8] read_count, [30:15] discard_count, [31] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] op
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  // [7:0] read_data, [20:8] fill_level, [23:21] zero
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status, [2] data_valid
  input  wire logic [OUT_TUSER_W-1:0] out_tuser,
  input  wire logic                   out_tlast,
  output int                          fail_count,
  output int                          pending
);

  // One expected result
  typedef struct {
    status_t       status;
    logic [BW-1:0] rdata;
    logic          dvalid;
    logic [FW-1:0] fill;
    logic          last;
  } fifo_result_t;

  logic [BW-1:0] ring_bytes [DEPTH];
  logic [AW-1:0] head_ptr;
  logic [AW-1:0] tail_ptr;
  int            held;
  int            results_seen;
  fifo_result_t  fifo_results [$];

  // Print one mismatch and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: result %0d: %s mismatch, got %0d want %0d",
             $time, results_seen, what, got, want);
    fail_count++;
  endtask

  // Apply one request to the ring copy and queue the results it causes
  task automatic predict_request(input logic [OPW-1:0] op, input logic [BW-1:0] wbyte,
                                 input logic [RCW-1:0] rcnt, input logic [DCW-1:0] dcnt);
    int           n;
    fifo_result_t r;
    r.status = ST_OK;
    r.rdata  = '0;
    r.dvalid = 1'b0;
    r.last   = 1'b1;
    case (op)
      OP_WRITE: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_bytes[tail_ptr] = wbyte;
          tail_ptr = tail_ptr + 1'b1;
          held++;
        end
      end
      OP_READ: begin
        n = (rcnt > MAX_READ) ? MAX_READ : int'(rcnt);
        if (n > held) begin
          r.status = ST_SHORT;
        end else if (n > 0) begin
          // emit one result per byte taken from the head
          for (int k = 0; k < n; k++) begin
            r.rdata  = ring_bytes[head_ptr];
            r.dvalid = 1'b1;
            head_ptr = head_ptr + 1'b1;
            held--;
            r.fill   = FW'(held);
            r.last   = (k == n - 1);
            fifo_results.push_back(r);
          end
          return;
        end
      end
      OP_DISCARD: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // drop at most what is held
          n = (int'(dcnt) < held) ? int'(dcnt) : held;
          head_ptr = head_ptr + AW'(n);
          held -= n;
        end
      end
      default: ;
    endcase
    r.fill = FW'(held);
    fifo_results.push_back(r);
  endtask

  // Predict on accepted requests, then compare accepted results
  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst_n) begin
      head_ptr = '0;
      tail_ptr = '0;
      held = 0;
      results_seen = 0;
      fifo_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        predict_request(in_tuser[OPW-1:0], in_tdata[7:0], in_tdata[14:8], in_tdata[30:15]);
      if (out_tvalid && out_tready) begin
        if (fifo_results.size() == 0) begin
          report_mismatch("unexpected result, status", int'(out_tuser), 0);
        end else begin
          want = fifo_results.pop_front();
          if (out_tuser[1:0] !== want.status)
            report_mismatch("status", int'(out_tuser[1:0]), int'(want.status));
          if (out_tdata[7:0] !== want.rdata)
            report_mismatch("read_data", int'(out_tdata[7:0]), int'(want.rdata));
          if (out_tuser[2] !== want.dvalid)
            report_mismatch("data_valid", int'(out_tuser[2]), int'(want.dvalid));
          if (out_tdata[20:8] !== want.fill)
            report_mismatch("fill_level", int'(out_tdata[20:8]), int'(want.fill));
          if (out_tlast !== want.last)
            report_mismatch("last", int'(out_tlast), int'(want.last));
          if (out_tdata[23:21] !== 3'b000)
            report_mismatch("tdata padding", int'(out_tdata[23:21]), 0);
        end
        results_seen++;
      end
    end
    pending = fifo_results.size();
  end

endmodule

// File: test/byte_ring_buffer_fifo_core_test.sv
// ----------------------------------------------------------------------------
// Byte ring buffer FIFO core testbench
// Drives write, read, discard and unused requests into the FIFO core: a
// directed pass over the corner cases, then random traffic under changing
// idle rates and long output stalls. The checker instance predicts and
// compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_ring_buffer_fifo_core_test;
  import brbf_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int held_est = 0;

  byte_ring_buffer_fifo_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  byte_ring_buffer_fifo_core_check checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Drain results; hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      out_tready <= 1'b0;
      hold_left <= 300;
      hold_seen <= hold_seen + 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one request, with random gaps before it, and wait for acceptance
  task automatic send_request(input logic [OPW-1:0] op, input logic [BW-1:0] wbyte,
                              input logic [RCW-1:0] rcnt, input logic [DCW-1:0] dcnt);
    int n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, dcnt, rcnt, wbyte};
    do @(posedge clk); while (!in_tready);
    // track the fill level to shape later requests
    case (op)
      OP_WRITE:   if (held_est < DEPTH) held_est++;
      OP_READ: begin
        n = (rcnt > MAX_READ) ? MAX_READ : int'(rcnt);
        if (n <= held_est) held_est -= n;
      end
      OP_DISCARD: held_est -= (int'(dcnt) < held_est) ? int'(dcnt) : held_est;
      default: ;
    endcase
  endtask

  // One random request, mostly writes and reads that fit the fill level
  task automatic send_random_request();
    int r;
    int lim;
    r = $urandom_range(0, 99);
    lim = (held_est < 16) ? held_est : 16;
    if (r < 45)
      send_request(OP_WRITE, BW'($urandom_range(0, 255)), RCW'($urandom_range(0, 127)),
                   DCW'($urandom_range(0, 65535)));
    else if (r < 75 && lim > 0)
      send_request(OP_READ, BW'($urandom_range(0, 255)), RCW'($urandom_range(1, lim)),
                   DCW'($urandom_range(0, 65535)));
    else if (r < 82)
      send_request(OP_READ, BW'($urandom_range(0, 255)), RCW'($urandom_range(0, 127)),
                   DCW'($urandom_range(0, 65535)));
    else if (r < 90)
      send_request(OP_DISCARD, BW'($urandom_range(0, 255)), RCW'($urandom_range(0, 127)),
                   DCW'($urandom_range(0, 8)));
    else if (r < 95)
      send_request(OP_DISCARD, BW'($urandom_range(0, 255)), RCW'($urandom_range(0, 127)),
                   DCW'($urandom_range(0, 65535)));
    else
      send_request(OP_NONE, BW'($urandom_range(0, 255)), RCW'($urandom_range(0, 127)),
                   DCW'($urandom_range(0, 65535)));
  endtask

  // Stimulus and verdict
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 24;
    recv_idle_pct = 53;

    // corner cases on an empty and a nearly empty buffer
    send_request(OP_READ, 8'h00, 7'd0, 16'd0);
    send_request(OP_READ, 8'h00, 7'd1, 16'd0);
    send_request(OP_DISCARD, 8'h00, 7'd0, 16'd5);
    send_request(OP_NONE, 8'hFF, 7'h7F, 16'hFFFF);
    send_request(OP_WRITE, 8'h00, 7'd0, 16'd0);
    send_request(OP_WRITE, 8'hFF, 7'd0, 16'd0);
    send_request(OP_WRITE, 8'hA5, 7'd0, 16'd0);
    send_request(OP_WRITE, 8'h5A, 7'd0, 16'd0);
    send_request(OP_READ, 8'h00, 7'd2, 16'd0);
    send_request(OP_READ, 8'h00, 7'd3, 16'd0);
    send_request(OP_DISCARD, 8'h00, 7'd0, 16'd0);
    send_request(OP_READ, 8'h00, 7'd2, 16'd0);
    send_request(OP_WRITE, 8'h3C, 7'd0, 16'd0);
    send_request(OP_WRITE, 8'hC3, 7'd0, 16'd0);
    send_request(OP_WRITE, 8'h81, 7'd0, 16'd0);
    send_request(OP_DISCARD, 8'h00, 7'd0, 16'hFFFF);
    send_request(OP_DISCARD, 8'h00, 7'd0, 16'd1);
    send_request(OP_READ, 8'h00, 7'd0, 16'd0);

    // random traffic in three idle regimes, with long output stalls
    for (int i = 0; i < 362; i++) begin
      if (i == 109) begin
        send_idle_pct = 53;
        recv_idle_pct = 24;
      end else if (i == 236) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 40 || i == 300) hold_reqs++;
      send_random_request();
    end
    in_tvalid <= 1'b0;

    // wait for the last results, then let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
